// File: design/csws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csws_pkg;

   localparam int OFF_W      = 23;
   localparam int DATA_W     = 64;
   localparam int CNT_W      = 16;
   localparam int OP_W       = 3;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DATA_W-1:0] INIT_DATA    = 64'h0003_0002_0001_0000;
   localparam logic [DATA_W-1:0] ADDR_STEP    = 64'h0004_0004_0004_0004;
   localparam logic [OFF_W-1:0]  FIRST_OFFSET = 23'h10;
   localparam logic [OFF_W-1:0]  LOW_NIBBLE   = 23'h0f;
   localparam logic [OFF_W-1:0]  WORD_BYTES   = 23'h8;

   localparam logic [CFG_W-1:0] SIZE_LOG2_MIN   = 5'd8;
   localparam logic [CFG_W-1:0] SIZE_LOG2_MAX   = 5'd22;
   localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 5'd20;

   // register index is paddr bit 2 (registers sit 4 bytes apart)
   localparam logic REG_CACHE_SIZE = 1'b0;

   localparam logic CMD_START   = 1'b0;
   localparam logic REGION_SCRATCH = 1'b0;
   localparam logic REGION_FLUSH   = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 3'd0,
      OP_CHECK = 3'd1,
      OP_TOUCH = 3'd2,
      OP_FLUSH = 3'd3,
      OP_DONE  = 3'd4
   } op_kind_type;

   typedef enum logic [3:0] {
      PH_D1,
      PH_D0,
      PH_REINIT,
      PH_A1W,
      PH_A1V,
      PH_A1C,
      PH_A0W,
      PH_A0V,
      PH_A0C,
      PH_FLUSH,
      PH_DONE
   } phase_type;

endpackage

`default_nettype wire

// File: design/csws_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csws_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [csws_pkg::DATA_W-1:0]  read_data;

   modport source (output valid, output cmd, output read_data, input ready);
   modport sink   (input valid, input cmd, input read_data, output ready);
endinterface

`default_nettype wire

// File: design/csws_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface csws_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [csws_pkg::OP_W-1:0]    op_kind;
   logic                         region;
   logic [csws_pkg::OFF_W-1:0]   byte_offset;
   logic [csws_pkg::DATA_W-1:0]  word_value;
   logic                         mismatch;
   logic [csws_pkg::CNT_W-1:0]   error_total;

   modport source (output valid, output op_kind, output region, output byte_offset,
                   output word_value, output mismatch, output error_total, input ready);
   modport sink   (input valid, input op_kind, input region, input byte_offset,
                   input word_value, input mismatch, input error_total, output ready);
endinterface

`default_nettype wire

// File: design/csws_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module csws_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [csws_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [csws_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [csws_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output logic      [csws_pkg::CFG_W-1:0]        size_log2
);

   logic [csws_pkg::CFG_W-1:0] size_log2_ff;
   logic                       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == csws_pkg::REG_CACHE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= csws_pkg::SIZE_LOG2_RESET;
      end else if (wr_hit) begin
         size_log2_ff <= csr_pwdata[csws_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == csws_pkg::REG_CACHE_SIZE) begin
         csr_prdata = csws_pkg::CSR_DATA_W'(size_log2_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign size_log2 = size_log2_ff;

endmodule

`default_nettype wire

// File: design/cache_sram_walk_test_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Memory test sequencer: every accepted request beat yields exactly one memory
// operation on the response channel through a single output register; a new
// beat is taken every cycle as long as the response register is empty or
// being drained in the same cycle, so the sustained rate is one operation per
// clock. A start beat (cmd 0) restarts the run at once; the data of a
// read-check is compared when it comes back with the following beat, unless
// that beat is a start beat. The cache size register may only be changed
// between beats; a synchronous reset leaves the sequencer in the done state.

module cache_sram_walk_test_sequencer #(
   parameter int LINE_WORDS = 2,
   parameter int WORD_BITS  = 64,
   parameter int L1_SPAN    = 32768
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   csws_req_if.sink                               req,
   csws_rsp_if.source                             rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [csws_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [csws_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [csws_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   localparam int OFF_W  = csws_pkg::OFF_W;
   localparam int DATA_W = csws_pkg::DATA_W;
   localparam int CNT_W  = csws_pkg::CNT_W;
   localparam int LANE_W = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
   localparam int SUB_W  = $clog2(2 * LINE_WORDS + 3);
   localparam int BIT_W  = $clog2(WORD_BITS);

   localparam logic [DATA_W-1:0] WMASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
   localparam logic [SUB_W-1:0]  SUB_LANE    = SUB_W'(LINE_WORDS);
   localparam logic [SUB_W-1:0]  SUB_TOUCH0  = SUB_W'(LINE_WORDS + 1);
   localparam logic [SUB_W-1:0]  SUB_TOUCH1  = SUB_W'(LINE_WORDS + 2);
   localparam logic [SUB_W-1:0]  SUB_CHK0    = SUB_W'(LINE_WORDS + 3);
   localparam logic [SUB_W-1:0]  SUB_LAST    = SUB_W'(2 * LINE_WORDS + 2);
   localparam logic [SUB_W-1:0]  SUB_FILLCHK = SUB_W'(LINE_WORDS - 1);
   localparam logic [SUB_W-1:0]  SUB_ONE     = SUB_W'(1);
   localparam logic [SUB_W-1:0]  SUB_FAR     = SUB_W'(2);
   localparam logic [SUB_W-1:0]  SUB_TEND    = SUB_W'(3);
   localparam logic [BIT_W-1:0]  BIT_LAST    = BIT_W'(WORD_BITS - 1);
   localparam logic [LANE_W-1:0] LANE_LAST   = LANE_W'(LINE_WORDS - 1);
   localparam logic [OFF_W-1:0]  L1_FAR      = OFF_W'(L1_SPAN);
   localparam logic [OFF_W-1:0]  L1_NEAR     = OFF_W'(L1_SPAN / 2);

   // sequencer state
   csws_pkg::phase_type  phase_ff, phase_in, cur_phase, walk_phase;
   logic [LANE_W-1:0]    lane_ff, lane_in, cur_lane;
   logic [BIT_W-1:0]     bit_ff, bit_in, cur_bit;
   logic [SUB_W-1:0]     sub_ff, sub_in, cur_sub;
   logic [OFF_W-1:0]     walk_ff, walk_in, cur_walk;
   logic [DATA_W-1:0]    pattern_ff, pattern_in, cur_pattern;
   logic [DATA_W-1:0]    expected_ff, expected_in;
   logic                 pending_ff, pending_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // response register
   logic                 rsp_valid_ff;
   csws_pkg::op_kind_type op_ff, op_in;
   logic                 region_ff, region_in;
   logic [OFF_W-1:0]     offset_ff, offset_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic                 mismatch_ff, mismatch_in;

   logic                 accept;
   logic [csws_pkg::CFG_W-1:0] size_log2, size_log2_eff;
   logic [OFF_W-1:0]     size_bytes, size_half, size_mask, base;
   logic [OFF_W:0]       walk_shift;
   logic                 zero_walk, walk_step;
   logic [DATA_W-1:0]    walk_init, step_pattern, bit_word, fill_word, pat_word;
   logic [SUB_W-1:0]     chk_k, chk_word;

   csws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .size_log2   (size_log2)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // clamp size to the supported range
   always_comb begin
      if (size_log2 < csws_pkg::SIZE_LOG2_MIN) begin
         size_log2_eff = csws_pkg::SIZE_LOG2_MIN;
      end else if (size_log2 > csws_pkg::SIZE_LOG2_MAX) begin
         size_log2_eff = csws_pkg::SIZE_LOG2_MAX;
      end else begin
         size_log2_eff = size_log2;
      end
   end

   assign size_bytes = OFF_W'(1) << size_log2_eff;
   assign size_half  = size_bytes >> 1;
   assign size_mask  = (size_bytes - OFF_W'(1)) & ~csws_pkg::LOW_NIBBLE;

   always_comb begin
      // a start beat restarts the run before this step's operation
      cur_phase   = phase_ff;
      cur_lane    = lane_ff;
      cur_bit     = bit_ff;
      cur_sub     = sub_ff;
      cur_walk    = walk_ff;
      cur_pattern = pattern_ff;
      count_in    = count_ff;
      mismatch_in = 1'b0;
      if (req.cmd == csws_pkg::CMD_START) begin
         cur_phase   = csws_pkg::PH_D1;
         cur_lane    = '0;
         cur_bit     = '0;
         cur_sub     = '0;
         cur_walk    = csws_pkg::FIRST_OFFSET;
         cur_pattern = '0;
         count_in    = '0;
      end else if (pending_ff && ((req.read_data & WMASK) != expected_ff)) begin
         mismatch_in = 1'b1;
         if (count_ff != {CNT_W{1'b1}}) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign zero_walk    = cur_phase inside {csws_pkg::PH_A0W, csws_pkg::PH_A0V,
                                           csws_pkg::PH_A0C};
   assign base         = zero_walk ? (~cur_walk & size_mask) : cur_walk;
   assign step_pattern = (zero_walk ? (cur_pattern - csws_pkg::ADDR_STEP)
                                    : (cur_pattern + csws_pkg::ADDR_STEP)) & WMASK;
   assign walk_shift   = {1'b0, cur_walk} << 1;
   assign bit_word     = (DATA_W'(1) << cur_bit) & WMASK;
   assign fill_word    = (cur_phase == csws_pkg::PH_D0) ? WMASK : '0;
   assign pat_word     = (cur_phase == csws_pkg::PH_D0) ? (~bit_word & WMASK) : bit_word;
   assign chk_k        = cur_sub - SUB_CHK0;
   // skip the lane while checking the fill words
   assign chk_word     = (chk_k < SUB_W'(cur_lane)) ? chk_k : chk_k + SUB_ONE;

   always_comb begin
      op_in       = csws_pkg::OP_DONE;
      region_in   = csws_pkg::REGION_SCRATCH;
      offset_in   = '0;
      value_in    = '0;
      phase_in    = cur_phase;
      lane_in     = cur_lane;
      bit_in      = cur_bit;
      sub_in      = cur_sub;
      walk_in     = cur_walk;
      pattern_in  = cur_pattern;
      walk_step   = 1'b0;
      walk_phase  = cur_phase;
      walk_init   = '0;

      case (cur_phase)
         csws_pkg::PH_D1, csws_pkg::PH_D0: begin
            if (cur_sub < SUB_LANE) begin
               op_in     = csws_pkg::OP_WRITE;
               offset_in = OFF_W'({cur_sub, 3'b000});
               value_in  = fill_word;
            end else if (cur_sub == SUB_LANE) begin
               op_in     = csws_pkg::OP_WRITE;
               offset_in = OFF_W'({cur_lane, 3'b000});
               value_in  = pat_word;
            end else if (cur_sub == SUB_TOUCH0) begin
               op_in     = csws_pkg::OP_TOUCH;
               region_in = csws_pkg::REGION_FLUSH;
            end else if (cur_sub == SUB_TOUCH1) begin
               op_in     = csws_pkg::OP_TOUCH;
               region_in = csws_pkg::REGION_FLUSH;
               offset_in = size_half;
            end else begin
               op_in = csws_pkg::OP_CHECK;
               if (chk_k < SUB_FILLCHK) begin
                  offset_in = OFF_W'({chk_word, 3'b000});
                  value_in  = fill_word;
               end else begin
                  offset_in = OFF_W'({cur_lane, 3'b000});
                  value_in  = pat_word;
               end
            end
            sub_in = cur_sub + SUB_ONE;
            if (cur_sub == SUB_LAST) begin
               sub_in = '0;
               bit_in = cur_bit + BIT_W'(1);
               if (cur_bit == BIT_LAST) begin
                  bit_in = '0;
                  if (cur_phase == csws_pkg::PH_D1) begin
                     phase_in = csws_pkg::PH_D0;
                  end else begin
                     phase_in = csws_pkg::PH_D1;
                     lane_in  = cur_lane + LANE_W'(1);
                     if (cur_lane == LANE_LAST) begin
                        lane_in  = '0;
                        phase_in = csws_pkg::PH_REINIT;
                     end
                  end
               end
            end
         end
         csws_pkg::PH_REINIT: begin
            op_in     = csws_pkg::OP_WRITE;
            offset_in = OFF_W'({cur_sub, 3'b000});
            sub_in    = cur_sub + SUB_ONE;
            if (cur_sub >= SUB_FILLCHK) begin
               sub_in     = '0;
               phase_in   = csws_pkg::PH_A1W;
               walk_in    = csws_pkg::FIRST_OFFSET;
               pattern_in = csws_pkg::INIT_DATA & WMASK;
            end
         end
         csws_pkg::PH_A1W, csws_pkg::PH_A0W: begin
            sub_in = cur_sub + SUB_ONE;
            if (cur_sub < SUB_FAR) begin
               op_in      = csws_pkg::OP_WRITE;
               offset_in  = base + OFF_W'({cur_sub, 3'b000});
               value_in   = cur_pattern;
               pattern_in = step_pattern;
            end else begin
               op_in     = csws_pkg::OP_TOUCH;
               offset_in = (base + csws_pkg::WORD_BYTES)
                           ^ ((cur_sub == SUB_FAR) ? L1_FAR : L1_NEAR);
               if (cur_sub >= SUB_TEND) begin
                  sub_in    = '0;
                  walk_step = 1'b1;
                  if (cur_phase == csws_pkg::PH_A1W) begin
                     walk_phase = csws_pkg::PH_A1V;
                     walk_init  = csws_pkg::INIT_DATA;
                  end else begin
                     walk_phase = csws_pkg::PH_A0V;
                     walk_init  = ~csws_pkg::INIT_DATA;
                  end
               end
            end
         end
         csws_pkg::PH_A1V, csws_pkg::PH_A0V: begin
            op_in      = csws_pkg::OP_CHECK;
            offset_in  = base + OFF_W'({cur_sub[0], 3'b000});
            value_in   = cur_pattern;
            pattern_in = step_pattern;
            sub_in     = cur_sub + SUB_ONE;
            if (cur_sub != '0) begin
               sub_in     = '0;
               walk_step  = 1'b1;
               walk_phase = (cur_phase == csws_pkg::PH_A1V) ? csws_pkg::PH_A1C
                                                            : csws_pkg::PH_A0C;
            end
         end
         csws_pkg::PH_A1C, csws_pkg::PH_A0C: begin
            op_in     = csws_pkg::OP_WRITE;
            offset_in = base + OFF_W'({cur_sub[0], 3'b000});
            sub_in    = cur_sub + SUB_ONE;
            if (cur_sub != '0) begin
               sub_in    = '0;
               walk_step = 1'b1;
               if (cur_phase == csws_pkg::PH_A1C) begin
                  walk_phase = csws_pkg::PH_A0W;
                  walk_init  = ~csws_pkg::INIT_DATA;
               end else begin
                  walk_phase = csws_pkg::PH_FLUSH;
               end
            end
         end
         csws_pkg::PH_FLUSH: begin
            op_in    = csws_pkg::OP_FLUSH;
            phase_in = csws_pkg::PH_DONE;
         end
         default: begin
            op_in = csws_pkg::OP_DONE;
         end
      endcase

      // advance the walk; wrap to the next pass once it reaches the cache size
      if (walk_step) begin
         walk_in = walk_shift[OFF_W-1:0];
         if (walk_shift >= {1'b0, size_bytes}) begin
            walk_in    = csws_pkg::FIRST_OFFSET;
            pattern_in = walk_init & WMASK;
            phase_in   = walk_phase;
         end
      end

      pending_in  = (op_in == csws_pkg::OP_CHECK);
      expected_in = pending_in ? (value_in & WMASK) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= csws_pkg::PH_DONE;
         lane_ff     <= '0;
         bit_ff      <= '0;
         sub_ff      <= '0;
         walk_ff     <= csws_pkg::FIRST_OFFSET;
         pattern_ff  <= '0;
         expected_ff <= '0;
         pending_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         lane_ff     <= lane_in;
         bit_ff      <= bit_in;
         sub_ff      <= sub_in;
         walk_ff     <= walk_in;
         pattern_ff  <= pattern_in;
         expected_ff <= expected_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the payload until the next accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_in;
         region_ff   <= region_in;
         offset_ff   <= offset_in;
         value_ff    <= value_in & WMASK;
         mismatch_ff <= mismatch_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.op_kind     = op_ff;
   assign rsp.region      = region_ff;
   assign rsp.byte_offset = offset_ff;
   assign rsp.word_value  = value_ff;
   assign rsp.mismatch    = mismatch_ff;
   assign rsp.error_total = count_ff;

endmodule

`default_nettype wire
